>>> rtl/core/bas_pkg.sv
// Package for the battery alarm state machine: payload structs, state and
// report codes, configuration register indexes. No dependencies.
`default_nettype none

package bas_pkg;

  localparam int unsigned GaugeW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;
  localparam logic [GaugeW-1:0] GaugeRangeRst = 5'd10;
  localparam logic [GaugeW-1:0] FatalLevelRst = 5'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAUGE_RANGE = 2'd0,
    CFG_FATAL_LEVEL = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_GAUGE   = 3'd0,
    KIND_COMMAND = 3'd1,
    KIND_BUTTON  = 3'd2,
    KIND_WAYPT   = 3'd3,
    KIND_TICK    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LOW       = 3'd1,
    ST_LOW_STOP  = 3'd2,
    ST_LOW_RUN   = 3'd3,
    ST_EXCH_CONF = 3'd4,
    ST_EXCHANGE  = 3'd5,
    ST_EXCH_STOP = 3'd6,
    ST_FATAL     = 3'd7
  } alarm_e;

  typedef enum logic [1:0] {
    COL_NORMAL  = 2'd0,
    COL_WARNING = 2'd1,
    COL_ERROR   = 2'd2,
    COL_FATAL   = 2'd3
  } colour_e;

  typedef enum logic [1:0] {
    LVL_INFO  = 2'd0,
    LVL_ERROR = 2'd1,
    LVL_WARN  = 2'd2
  } level_e;

  typedef enum logic [2:0] {
    CODE_NONE       = 3'd0,
    CODE_LOW        = 3'd1,
    CODE_LOW_STOP   = 3'd2,
    CODE_EXCHANGE   = 3'd3,
    CODE_START_BLK  = 3'd4,
    CODE_EXCH_CONF  = 3'd5,
    CODE_EXCH_STOP  = 3'd6,
    CODE_ERROR      = 3'd7
  } code_e;

  typedef enum logic [1:0] {
    CHK_NONE       = 2'd0,
    CHK_CHECK_STOP = 2'd1,
    CHK_CHECK_ONLY = 2'd2,
    CHK_STOP_ONLY  = 2'd3
  } chk_mode_e;

  localparam logic signed [7:0]  CmdRun      = 8'sd1;
  localparam logic signed [7:0]  CmdExchange = 8'sd2;
  localparam logic signed [15:0] BtnPressed  = 16'sd1;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [7:0] scale_value;
    logic signed [7:0] command_value;
    logic signed [15:0] button_level;
    logic [15:0]       wp_id;
    logic [1:0]        exchange_check_mode;
    logic [4:0]        exchange_limit;
    logic [1:0]        low_check_mode;
    logic [4:0]        low_limit;
  } in_item_t;

  typedef struct packed {
    logic        status_valid;
    logic [2:0]  battery_state;
    logic [4:0]  gauge;
    logic [1:0]  colour;
    logic        monitor_valid;
    logic [1:0]  monitor_level;
    logic [2:0]  monitor_code;
  } out_item_t;

  // Decision for one item, shared by the next-state and output logic.
  typedef struct packed {
    logic   st_emit;
    alarm_e st_val;
    logic   mon_emit;
    level_e mon_lvl;
    code_e  mon_code;
    logic   chk_upd;
  } act_t;

endpackage

`default_nettype wire

>>> rtl/core/battery_alarm_state_machine.sv
// Battery alarm state machine, top level.
// Depends on bas_pkg for payload structs, state and report codes.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i) takes one item per cycle
//    while in_ready_o is high: gauge update, operator command, start button,
//    waypoint or tick. Output channel (out_valid_o/out_ready_i/out_data_o) gives
//    at most one result item per input item, in order. Gauge updates, waypoints,
//    rejected commands/buttons and unused kinds give nothing.
//  - Config channel (cfg_valid_i/cfg_ready_o) writes gauge_range (index 0) or
//    fatal_level (index 1); always ready. Write only while the block is idle.
//  - Path: an accepted item waits in the input register, is decided by the
//    compare logic, and its result is offered from the result register.
//  - Throughput: one item per cycle unless stalled. The decision is a single
//    pass of compares between the input register and the result register;
//    the alarm state updates in the same cycle; the next item sees it at once.
//  - Receiver stall: the result register holds its item; the input register
//    still takes one more item, then in_ready_o drops until the result leaves.
//  - Reset: alarm state ok, colour normal, gauge and waypoint data zero,
//    gauge_range 10, fatal_level 2, both channels empty.
`default_nettype none

module battery_alarm_state_machine
  import bas_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [GaugeW-1:0] range_q, fatal_q;

  // input register
  logic     in_valid_q;
  in_item_t in_q;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  // block state
  alarm_e            alarm_q, alarm_d;
  logic [1:0]        colour_q, colour_d;
  logic [1:0]        lvl_q;
  logic [2:0]        code_q;
  logic [GaugeW-1:0] gauge_q, gauge_d;
  logic [15:0]       here_q, checked_q;
  logic [1:0]        exch_mode_q, low_mode_q;
  logic [4:0]        exch_lim_q, low_lim_q;

  logic      out_free, fire;
  act_t      act;
  out_item_t res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= GaugeRangeRst;
      fatal_q <= FatalLevelRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAUGE_RANGE: range_q <= cfg_data_i;
        CFG_FATAL_LEVEL: fatal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Gauge clamp to 0..range (signed reading against unsigned range)
  // ---------------------------------------------------------------------
  always_comb begin
    gauge_d = gauge_q;
    if (fire && kind_e'(in_q.kind) == KIND_GAUGE) begin
      priority if (in_q.scale_value >= $signed({3'b000, range_q})) begin
        gauge_d = range_q;
      end else if (in_q.scale_value <= 8'sd0) begin
        gauge_d = '0;
      end else begin
        gauge_d = in_q.scale_value[GaugeW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rule evaluation: decides the status/monitor reports for one item
  // ---------------------------------------------------------------------
  logic exch_hit, low_hit;

  always_comb begin
    unique case (chk_mode_e'(exch_mode_q))
      CHK_CHECK_STOP, CHK_CHECK_ONLY: exch_hit = (gauge_q <= exch_lim_q);
      CHK_STOP_ONLY:                  exch_hit = (alarm_q == ST_EXCHANGE);
      default:                        exch_hit = 1'b0;
    endcase
    unique case (chk_mode_e'(low_mode_q))
      CHK_CHECK_STOP, CHK_CHECK_ONLY: low_hit = (gauge_q <= low_lim_q);
      CHK_STOP_ONLY:                  low_hit = (alarm_q == ST_LOW);
      default:                        low_hit = 1'b0;
    endcase
  end

  always_comb begin
    act          = '0;
    act.st_val   = alarm_q;
    act.mon_lvl  = level_e'(lvl_q);
    act.mon_code = code_e'(code_q);
    if (fire) begin
      unique case (kind_e'(in_q.kind))
        KIND_COMMAND: begin
          if (alarm_q == ST_LOW_STOP) begin
            if (in_q.command_value == CmdRun) begin
              act.st_emit  = 1'b1;
              act.st_val   = ST_LOW_RUN;
              act.mon_emit = 1'b1;
              act.mon_lvl  = LVL_INFO;
              act.mon_code = CODE_NONE;
            end else if (in_q.command_value == CmdExchange) begin
              act.st_emit  = 1'b1;
              act.st_val   = ST_EXCH_CONF;
              act.mon_emit = 1'b1;
              act.mon_lvl  = LVL_WARN;
              act.mon_code = CODE_EXCH_CONF;
            end
          end
        end
        KIND_BUTTON: begin
          if (alarm_q == ST_LOW_STOP && in_q.button_level == BtnPressed) begin
            act.mon_emit = 1'b1;
            act.mon_lvl  = LVL_WARN;
            act.mon_code = CODE_START_BLK;
          end
        end
        KIND_TICK: begin
          act.st_emit = 1'b1;
          priority if (gauge_q == '0) begin
            act.st_val = ST_OK;
          end else if (alarm_q != ST_OK && here_q == checked_q) begin
            // still on the same waypoint: repeat last reports
            act.mon_emit = 1'b1;
          end else begin
            act.chk_upd = 1'b1;
            priority if (gauge_q <= fatal_q) begin
              act.st_val   = ST_FATAL;
              act.mon_emit = 1'b1;
              act.mon_lvl  = LVL_ERROR;
              act.mon_code = CODE_ERROR;
            end else if (exch_hit) begin
              act.mon_emit = 1'b1;
              if (chk_mode_e'(exch_mode_q) == CHK_CHECK_ONLY) begin
                act.st_val   = ST_EXCHANGE;
                act.mon_lvl  = LVL_WARN;
                act.mon_code = CODE_EXCHANGE;
              end else begin
                act.st_val   = ST_EXCH_STOP;
                act.mon_lvl  = LVL_ERROR;
                act.mon_code = CODE_EXCH_STOP;
              end
            end else if (low_hit) begin
              act.mon_emit = 1'b1;
              act.mon_lvl  = LVL_WARN;
              if (chk_mode_e'(low_mode_q) == CHK_CHECK_ONLY) begin
                act.st_val   = ST_LOW;
                act.mon_code = CODE_LOW;
              end else begin
                act.st_val   = ST_LOW_STOP;
                act.mon_code = CODE_LOW_STOP;
              end
            end else if (alarm_q == ST_OK || alarm_q == ST_LOW_RUN) begin
              act.st_val = ST_OK;
            end else begin
              act.mon_emit = 1'b1;    // hold current alarm
            end
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    alarm_d = act.st_emit ? act.st_val : alarm_q;
  end

  // outputs: sticky colour and the result item
  always_comb begin
    unique case (alarm_d)
      ST_LOW, ST_LOW_STOP:       colour_d = COL_WARNING;
      ST_EXCHANGE, ST_EXCH_STOP: colour_d = COL_ERROR;
      ST_FATAL:                  colour_d = COL_FATAL;
      default:                   colour_d = colour_q;
    endcase
    res = '0;
    if (act.st_emit) begin
      res.status_valid  = 1'b1;
      res.battery_state = alarm_d;
      res.gauge         = gauge_q;
      res.colour        = colour_d;
    end
    if (act.mon_emit) begin
      res.monitor_valid = 1'b1;
      res.monitor_level = act.mon_lvl;
      res.monitor_code  = act.mon_code;
    end
  end

  // ---------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q     <= ST_OK;
      colour_q    <= COL_NORMAL;
      lvl_q       <= LVL_INFO;
      code_q      <= CODE_NONE;
      gauge_q     <= '0;
      here_q      <= '0;
      checked_q   <= '0;
      exch_mode_q <= CHK_NONE;
      exch_lim_q  <= '0;
      low_mode_q  <= CHK_NONE;
      low_lim_q   <= '0;
    end else begin
      alarm_q <= alarm_d;
      gauge_q <= gauge_d;
      if (act.st_emit) begin
        colour_q <= colour_d;
      end
      if (act.mon_emit) begin
        lvl_q  <= act.mon_lvl;
        code_q <= act.mon_code;
      end
      if (act.chk_upd) begin
        checked_q <= here_q;
      end
      if (fire && kind_e'(in_q.kind) == KIND_WAYPT) begin
        here_q      <= in_q.wp_id;
        exch_mode_q <= in_q.exchange_check_mode;
        exch_lim_q  <= in_q.exchange_limit;
        low_mode_q  <= in_q.low_check_mode;
        low_lim_q   <= in_q.low_limit;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= act.st_emit || act.mon_emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tick_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && kind_e'(in_q.kind) == KIND_TICK |=> out_valid_q && out_q.status_valid)
    else $error("tick did not produce a status item");

  a_no_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.status_valid || out_q.monitor_valid)
    else $error("result item carries no report");

  a_fatal_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status_valid && out_q.battery_state == ST_FATAL
      |-> out_q.colour == COL_FATAL)
    else $error("fatal status without fatal colour");

  a_monitor_only_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.status_valid |-> out_q.monitor_code == CODE_START_BLK)
    else $error("monitor-only item is not a blocked start");

endmodule

`default_nettype wire
